// ===== src/dems_pkg.sv =====
// Shared types, constants and helper functions of the two-motor encoder drive.
// No dependencies; every other file of the block imports this package.
package dems_pkg;

  localparam int ActW     = 3;
  localparam int ModeW    = 4;
  localparam int TickW    = 16;
  localparam int SixW     = 16;
  localparam int PwmW     = 8;
  localparam int BrW      = 2;
  localparam int GainW    = 8;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;
  localparam int DivBits  = TickW;
  localparam int DivCntW  = $clog2(DivBits);

  localparam logic [TickW-1:0] TicksRst = TickW'(8);
  localparam logic [GainW-1:0] GainRst  = GainW'(1);

  // Request codes
  typedef enum logic [ActW-1:0] {
    ACT_START    = 3'd0,
    ACT_TICK_A   = 3'd1,
    ACT_TICK_B   = 3'd2,
    ACT_CONTROL  = 3'd3,
    ACT_STOP_ALL = 3'd4,
    ACT_STOP_A   = 3'd5,
    ACT_STOP_B   = 3'd6
  } action_t;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TICKS = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN  = 1'd1;

  // Bridge codes: bit1 in1, bit0 in2
  localparam logic [BrW-1:0] BR_COAST = 2'd0;
  localparam logic [BrW-1:0] BR_REV   = 2'd1;
  localparam logic [BrW-1:0] BR_FWD   = 2'd2;
  localparam logic [BrW-1:0] BR_BRAKE = 2'd3;

  // Mode group boundaries
  localparam logic [ModeW-1:0] MODE_A_ONLY = 4'd4;
  localparam logic [ModeW-1:0] MODE_B_ONLY = 4'd8;
  localparam logic [ModeW-1:0] MODE_LIMIT  = 4'd12;

  typedef struct packed {
    logic item_load;
    logic div_load;
    logic div_step;
    logic commit;
  } dems_cmd_t;

  typedef struct packed {
    logic need_div;
  } dems_sts_t;

  function automatic logic uses_a(input logic [ModeW-1:0] m);
    return m < MODE_B_ONLY;
  endfunction

  function automatic logic uses_b(input logic [ModeW-1:0] m);
    return (m < MODE_A_ONLY) || ((m >= MODE_B_ONLY) && (m < MODE_LIMIT));
  endfunction

  // Direction of A for the low two mode bits: fwd, back, spin right, spin left
  function automatic logic [BrW-1:0] dir_a(input logic [1:0] d);
    logic [BrW-1:0] r;
    unique case (d)
      2'd0: r = BR_FWD;
      2'd1: r = BR_REV;
      2'd2: r = BR_FWD;
      2'd3: r = BR_REV;
    endcase
    return r;
  endfunction

  function automatic logic [BrW-1:0] dir_b(input logic [1:0] d);
    logic [BrW-1:0] r;
    unique case (d)
      2'd0: r = BR_FWD;
      2'd1: r = BR_REV;
      2'd2: r = BR_REV;
      2'd3: r = BR_FWD;
    endcase
    return r;
  endfunction

endpackage

// ===== src/dems_in_if.sv =====
// Request channel of the motor drive: valid/ready and the request fields.
// Depends on dems_pkg for field widths.
interface dems_in_if;
  import dems_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [ActW-1:0]        action;
  logic [ModeW-1:0]       mode;
  logic [SixW-1:0]        target_sixteenths;
  logic [PwmW-1:0]        speed;

  modport source (output valid, action, mode, target_sixteenths, speed, input ready);
  modport sink   (input valid, action, mode, target_sixteenths, speed, output ready);
endinterface

// ===== src/dems_out_if.sv =====
// Result channel of the motor drive: valid/ready and the drive outputs.
// Depends on dems_pkg for field widths.
interface dems_out_if;
  import dems_pkg::*;
  logic             valid;
  logic             ready;
  logic [PwmW-1:0]  pwm_a;
  logic [PwmW-1:0]  pwm_b;
  logic [BrW-1:0]   bridge_a;
  logic [BrW-1:0]   bridge_b;
  logic             busy_res;
  logic             done_res;

  modport source (output valid, pwm_a, pwm_b, bridge_a, bridge_b, busy_res, done_res,
                  input ready);
  modport sink   (input valid, pwm_a, pwm_b, bridge_a, bridge_b, busy_res, done_res,
                  output ready);
endinterface

// ===== src/dems_cfg_if.sv =====
// Configuration write channel of the motor drive: valid/ready, index, data.
// Depends on dems_pkg for field widths.
interface dems_cfg_if;
  import dems_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CfgIdxW-1:0]   idx;
  logic [CfgDataW-1:0]  wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

// ===== src/dems_ctrl.sv =====
// Sequencer of the motor drive: request intake, divider steps, result hand-off.
// Depends on dems_pkg for the command and status structs.
module dems_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output dems_pkg::dems_cmd_t cmd,
  input  dems_pkg::dems_sts_t sts
);
  import dems_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_COMMIT} state_t;

  state_t               state_r;
  logic [DivCntW-1:0]   cnt_r;
  logic                 out_valid_r;
  logic                 slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.item_load = in_valid && in_ready;
    cmd.div_load  = (state_r == S_LOAD) && sts.need_div;
    cmd.div_step  = (state_r == S_DIV);
    cmd.commit    = (state_r == S_COMMIT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_LOAD;
        end
        S_LOAD: begin
          cnt_r   <= '0;
          state_r <= sts.need_div ? S_DIV : S_COMMIT;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DivCntW'(DivBits - 1)) state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          // hold until the previous result has gone
          if (slot_free) state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_rise_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_COMMIT))
    else $error("result raised without a commit");

  a_div_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> ($past(state_r == S_LOAD) || $past(state_r == S_DIV)))
    else $error("divider stepped without a load");

  a_blocked_commit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && !slot_free) |=> (state_r == S_COMMIT && out_valid_r))
    else $error("pending result lost while output stalled");

endmodule

// ===== src/dems_dp.sv =====
// Datapath of the motor drive: config registers, move state, serial divider.
// Depends on dems_pkg; driven by commands from dems_ctrl.
module dems_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dems_pkg::dems_cmd_t    cmd,
  output dems_pkg::dems_sts_t    sts,
  input  logic [dems_pkg::ActW-1:0]     in_action,
  input  logic [dems_pkg::ModeW-1:0]    in_mode,
  input  logic [dems_pkg::SixW-1:0]     in_target,
  input  logic [dems_pkg::PwmW-1:0]     in_speed,
  input  logic                          cfg_we,
  input  logic [dems_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [dems_pkg::CfgDataW-1:0] cfg_data,
  output logic [dems_pkg::PwmW-1:0]     pwm_a,
  output logic [dems_pkg::PwmW-1:0]     pwm_b,
  output logic [dems_pkg::BrW-1:0]      bridge_a,
  output logic [dems_pkg::BrW-1:0]      bridge_b,
  output logic                          busy,
  output logic                          done
);
  import dems_pkg::*;

  // configuration
  logic [TickW-1:0] ticks_cfg_r;
  logic [GainW-1:0] gain_cfg_r;
  // latched request
  logic [ActW-1:0]  item_action_r;
  logic [ModeW-1:0] item_mode_r;
  logic [SixW-1:0]  item_target_r;
  logic [PwmW-1:0]  item_speed_r;
  // move state
  logic [TickW-1:0] tick_a_r, tick_a_nxt, tick_b_r, tick_b_nxt;
  logic [SixW-1:0]  six_a_r, six_a_nxt, six_b_r, six_b_nxt;
  logic [SixW-1:0]  target_r, target_nxt;
  logic [ModeW-1:0] mode_r, mode_nxt;
  logic             active_r, active_nxt;
  logic [PwmW-1:0]  pwm_a_r, pwm_a_nxt, pwm_b_r, pwm_b_nxt;
  logic [BrW-1:0]   br_a_r, br_a_nxt, br_b_r, br_b_nxt;
  logic             done_r, done_nxt;
  // divider
  logic [DivBits-1:0] div_quo_r;
  logic [GainW-1:0]   div_rem_r;
  logic               div_neg_r;

  logic [TickW-1:0]   lim;
  logic [GainW-1:0]   gain_k;
  logic [TickW-1:0]   tick_a_inc, tick_b_inc;
  logic               wrap_a, wrap_b;
  logic [SixW-1:0]    six_a_inc, six_b_inc;
  logic               ctl_en;
  logic [TickW:0]     diff;
  logic [TickW:0]     mag;
  logic [GainW:0]     shifted, shifted_sub;
  logic               ge;
  logic signed [DivBits+1:0] err, psum;
  logic [PwmW-1:0]    pwm_sat;
  logic               check, reached;

  assign lim    = (ticks_cfg_r == '0) ? TickW'(1) : ticks_cfg_r;
  assign gain_k = (gain_cfg_r == '0) ? GainW'(1) : gain_cfg_r;

  assign tick_a_inc = tick_a_r + 1'b1;
  assign tick_b_inc = tick_b_r + 1'b1;
  assign wrap_a     = tick_a_inc >= lim;
  assign wrap_b     = tick_b_inc >= lim;
  assign six_a_inc  = (six_a_r == '1) ? six_a_r : six_a_r + 1'b1;
  assign six_b_inc  = (six_b_r == '1) ? six_b_r : six_b_r + 1'b1;

  assign ctl_en       = active_r && (mode_r < MODE_A_ONLY);
  assign sts.need_div = (item_action_r == ACT_CONTROL) && ctl_en;

  // magnitude and sign of the tick difference for the divider
  assign diff = {1'b0, tick_a_r} - {1'b0, tick_b_r};
  assign mag  = diff[TickW] ? ((TickW+1)'(0) - diff) : diff;

  // one restoring step: remainder stays below the divisor
  assign shifted     = {div_rem_r, div_quo_r[DivBits-1]};
  assign shifted_sub = shifted - {1'b0, gain_k};
  assign ge          = shifted >= {1'b0, gain_k};

  assign err  = div_neg_r ? -$signed({2'b00, div_quo_r}) : $signed({2'b00, div_quo_r});
  assign psum = $signed({(DivBits+2-PwmW)'(0), pwm_b_r}) + err;

  always_comb begin
    if (psum < 0) begin
      pwm_sat = '0;
    end else if (psum > $signed((DivBits+2)'(255))) begin
      pwm_sat = '1;
    end else begin
      pwm_sat = psum[PwmW-1:0];
    end
  end

  always_comb begin
    tick_a_nxt = tick_a_r;
    tick_b_nxt = tick_b_r;
    six_a_nxt  = six_a_r;
    six_b_nxt  = six_b_r;
    target_nxt = target_r;
    mode_nxt   = mode_r;
    active_nxt = active_r;
    pwm_a_nxt  = pwm_a_r;
    pwm_b_nxt  = pwm_b_r;
    br_a_nxt   = br_a_r;
    br_b_nxt   = br_b_r;
    done_nxt   = 1'b0;
    check      = 1'b0;

    unique case (item_action_r)
      ACT_START: begin
        check = 1'b1;
        if (item_mode_r < MODE_LIMIT) begin
          // brake whatever the old move was driving
          if (active_r) begin
            if (uses_a(mode_r)) begin
              pwm_a_nxt = '0; br_a_nxt = BR_BRAKE; six_a_nxt = '0;
            end
            if (uses_b(mode_r)) begin
              pwm_b_nxt = '0; br_b_nxt = BR_BRAKE; six_b_nxt = '0;
            end
          end
          mode_nxt   = item_mode_r;
          target_nxt = item_target_r;
          active_nxt = 1'b1;
          if (item_mode_r < MODE_A_ONLY) begin
            tick_a_nxt = '0;
            tick_b_nxt = '0;
            six_a_nxt  = '0;
            six_b_nxt  = '0;
            pwm_a_nxt  = item_speed_r;
            pwm_b_nxt  = item_speed_r;
            br_a_nxt   = dir_a(item_mode_r[1:0]);
            br_b_nxt   = dir_b(item_mode_r[1:0]);
          end else if (item_mode_r < MODE_B_ONLY) begin
            six_a_nxt = '0;
            pwm_a_nxt = item_speed_r;
            br_a_nxt  = dir_a(item_mode_r[1:0]);
          end else begin
            six_b_nxt = '0;
            pwm_b_nxt = item_speed_r;
            br_b_nxt  = dir_b(item_mode_r[1:0]);
          end
        end
      end
      ACT_TICK_A: begin
        check      = 1'b1;
        tick_a_nxt = wrap_a ? '0 : tick_a_inc;
        six_a_nxt  = wrap_a ? six_a_inc : six_a_r;
      end
      ACT_TICK_B: begin
        check      = 1'b1;
        tick_b_nxt = wrap_b ? '0 : tick_b_inc;
        six_b_nxt  = wrap_b ? six_b_inc : six_b_r;
      end
      ACT_CONTROL: begin
        if (ctl_en) pwm_b_nxt = pwm_sat;
      end
      ACT_STOP_ALL: begin
        pwm_a_nxt = '0; br_a_nxt = BR_BRAKE; six_a_nxt = '0;
        pwm_b_nxt = '0; br_b_nxt = BR_BRAKE; six_b_nxt = '0;
        active_nxt = 1'b0;
      end
      ACT_STOP_A: begin
        pwm_a_nxt = '0; br_a_nxt = BR_BRAKE; six_a_nxt = '0;
        if (active_r && uses_a(mode_r)) active_nxt = 1'b0;
      end
      ACT_STOP_B: begin
        pwm_b_nxt = '0; br_b_nxt = BR_BRAKE; six_b_nxt = '0;
        if (active_r && uses_b(mode_r)) active_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    reached = (uses_a(mode_nxt) && (six_a_nxt >= target_nxt))
           || (uses_b(mode_nxt) && (six_b_nxt >= target_nxt));

    if (check && active_nxt && reached) begin
      if (uses_a(mode_nxt)) begin
        pwm_a_nxt = '0; br_a_nxt = BR_BRAKE; six_a_nxt = '0;
      end
      if (uses_b(mode_nxt)) begin
        pwm_b_nxt = '0; br_b_nxt = BR_BRAKE; six_b_nxt = '0;
      end
      active_nxt = 1'b0;
      done_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_cfg_r <= TicksRst;
      gain_cfg_r  <= GainRst;
      tick_a_r    <= '0;
      tick_b_r    <= '0;
      six_a_r     <= '0;
      six_b_r     <= '0;
      target_r    <= '0;
      mode_r      <= '0;
      active_r    <= 1'b0;
      pwm_a_r     <= '0;
      pwm_b_r     <= '0;
      br_a_r      <= BR_COAST;
      br_b_r      <= BR_COAST;
      done_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_TICKS: ticks_cfg_r <= cfg_data[TickW-1:0];
          CFG_GAIN:  gain_cfg_r  <= cfg_data[GainW-1:0];
        endcase
      end
      if (cmd.commit) begin
        tick_a_r <= tick_a_nxt;
        tick_b_r <= tick_b_nxt;
        six_a_r  <= six_a_nxt;
        six_b_r  <= six_b_nxt;
        target_r <= target_nxt;
        mode_r   <= mode_nxt;
        active_r <= active_nxt;
        pwm_a_r  <= pwm_a_nxt;
        pwm_b_r  <= pwm_b_nxt;
        br_a_r   <= br_a_nxt;
        br_b_r   <= br_b_nxt;
        done_r   <= done_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_action_r <= in_action;
      item_mode_r   <= in_mode;
      item_target_r <= in_target;
      item_speed_r  <= in_speed;
    end
    if (cmd.div_load) begin
      div_quo_r <= mag[DivBits-1:0];
      div_rem_r <= '0;
      div_neg_r <= diff[TickW];
    end else if (cmd.div_step) begin
      div_quo_r <= {div_quo_r[DivBits-2:0], ge};
      div_rem_r <= ge ? shifted_sub[GainW-1:0] : shifted[GainW-1:0];
    end
  end

  assign pwm_a    = pwm_a_r;
  assign pwm_b    = pwm_b_r;
  assign bridge_a = br_a_r;
  assign bridge_b = br_b_r;
  assign busy     = active_r;
  assign done     = done_r;

endmodule

// ===== src/dual_encoder_motor_move_sync.sv =====
// Top level of the two-motor encoder drive with proportional speed matching.
// Depends on dems_pkg, the three channel interfaces, dems_ctrl and dems_dp.
//
//   port     | dir | handshake     | carries
//   in_ch    | in  | valid/ready   | action, mode, target_sixteenths, speed
//   out_ch   | out | valid/ready   | pwm_a, pwm_b, bridge_a, bridge_b, busy_res, done_res
//   cfg_ch   | in  | valid/ready   | idx (0 ticks per sixteenth, 1 gain divisor), wdata
//
// A request passes the load and commit states before the next acceptance; a control
// period of a two-motor move also runs the 16-step restoring divider.
// in_ch.ready is high whenever the sequencer is idle, even while a result waits.
// A stalled out_ch holds the result; the following request is then kept at commit.
// cfg_ch.ready is always high. rst_n is synchronous, active low.
module dual_encoder_motor_move_sync (
  input logic        clk,
  input logic        rst_n,
  dems_in_if.sink    in_ch,
  dems_out_if.source out_ch,
  dems_cfg_if.sink   cfg_ch
);
  import dems_pkg::*;

  dems_cmd_t cmd;
  dems_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  dems_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  dems_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_action (in_ch.action),
    .in_mode   (in_ch.mode),
    .in_target (in_ch.target_sixteenths),
    .in_speed  (in_ch.speed),
    .cfg_we    (cfg_ch.valid),
    .cfg_idx   (cfg_ch.idx),
    .cfg_data  (cfg_ch.wdata),
    .pwm_a     (out_ch.pwm_a),
    .pwm_b     (out_ch.pwm_b),
    .bridge_a  (out_ch.bridge_a),
    .bridge_b  (out_ch.bridge_b),
    .busy      (out_ch.busy_res),
    .done      (out_ch.done_res)
  );

endmodule
